FILE: design/dsia_pkg.sv
// Shared types and constants for the dense slot index allocator.
`timescale 1ns / 1ps

package dsia_pkg;

   // Field widths of the request, response and register channels
   localparam int MODE_W     = 3;
   localparam int INDEX_W    = 8;
   localparam int STATUS_W   = 3;
   localparam int SLOT_OUT_W = 8;
   localparam int POS_OUT_W  = 8;
   localparam int USED_W     = 9;
   localparam int ACTIVE_W   = 9;

   // Stream and register bus widths
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // Register map: word index taken from paddr[2]
   localparam logic CSR_IDX_ACTIVE = 1'b0;
   localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 9'd256;

   // Request operations
   typedef enum logic [MODE_W-1:0] {
      OP_ALLOC     = 3'd0,
      OP_PEEK      = 3'd1,
      OP_FREE_SLOT = 3'd2,
      OP_FREE_POS  = 3'd3,
      OP_SLOT_OF   = 3'd4,
      OP_POS_OF    = 3'd5
   } op_type;

   // Response status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 3'd0,
      ST_FULL      = 3'd1,
      ST_EMPTY     = 3'd2,
      ST_NOT_ALLOC = 3'd3,
      ST_RANGE     = 3'd4
   } status_type;

   // Controller states
   typedef enum logic [2:0] {
      CTL_CLEAR,
      CTL_IDLE,
      CTL_EXEC,
      CTL_FETCH,
      CTL_RETIRE
   } ctl_state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic clear;       // write one identity entry of the clearing pass
      logic accept;      // capture request, launch first table reads
      logic finish;      // complete a single-read operation, load response
      logic fetch_last;  // free by position: read the last used entry
      logic free_move;   // move last used entry into the hole
      logic retire;      // park the freed slot, load response
   } dp_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic              err;
      logic              clear_last;
      logic              out_free;
   } dp_status_type;

endpackage

FILE: design/dsia_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module dsia_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port, and read port that holds its data when idle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/dsia_ctrl.sv
// Controller state machine sequencing table reads and writes per request.
`timescale 1ns / 1ps

module dsia_ctrl
   import dsia_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type stat,
   output dp_cmd_type    cmd
);

   ctl_state_type state_ff;
   ctl_state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CTL_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         CTL_CLEAR: begin
            cmd.clear = 1'b1;
            if (stat.clear_last) begin
               state_in = CTL_IDLE;
            end
         end
         CTL_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
            if (req_valid) begin
               state_in = CTL_EXEC;
            end
         end
         CTL_EXEC: begin
            if (!stat.err && stat.mode == OP_FREE_SLOT) begin
               cmd.free_move = 1'b1;
               state_in      = CTL_RETIRE;
            end else if (!stat.err && stat.mode == OP_FREE_POS) begin
               cmd.fetch_last = 1'b1;
               state_in       = CTL_FETCH;
            end else if (stat.out_free) begin
               cmd.finish = 1'b1;
               state_in   = CTL_IDLE;
            end
         end
         CTL_FETCH: begin
            cmd.free_move = 1'b1;
            state_in      = CTL_RETIRE;
         end
         CTL_RETIRE: begin
            if (stat.out_free) begin
               cmd.retire = 1'b1;
               state_in   = CTL_IDLE;
            end
         end
         default: begin
            state_in = CTL_IDLE;
         end
      endcase
   end

endmodule

FILE: design/dsia_datapath.sv
// Datapath: slot and position tables, use count, checks and response register.
`timescale 1ns / 1ps

module dsia_datapath
   import dsia_pkg::*;
#(
   parameter int POOL_SLOTS = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   input  dp_cmd_type            cmd,
   output dp_status_type         stat,
   input  logic [MODE_W-1:0]     req_mode,
   input  logic [INDEX_W-1:0]    req_index,
   input  logic [ACTIVE_W-1:0]   active_slots,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic [SLOT_OUT_W-1:0] rsp_slot,
   output logic [POS_OUT_W-1:0]  rsp_position,
   output logic [USED_W-1:0]     rsp_used_count
);

   localparam int SLOT_W  = $clog2(POOL_SLOTS);
   localparam int COUNT_W = $clog2(POOL_SLOTS + 1);
   localparam int CMP_W   = (COUNT_W > ACTIVE_W) ? COUNT_W : ACTIVE_W;

   // Control registers
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [SLOT_W-1:0]  clr_ff, clr_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // Payload registers
   logic [MODE_W-1:0]     mode_ff, mode_in;
   logic [INDEX_W-1:0]    idx_ff, idx_in;
   logic [SLOT_W-1:0]     s_ff, s_in;
   logic [SLOT_W-1:0]     hole_ff, hole_in;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [SLOT_OUT_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic [POS_OUT_W-1:0]  rsp_pos_ff, rsp_pos_in;
   logic [USED_W-1:0]     rsp_used_ff, rsp_used_in;

   // Table ports
   logic              a_we, a_re;
   logic [SLOT_W-1:0] a_wa, a_wd, a_ra, a_rd;
   logic              b_we, b_re;
   logic [SLOT_W-1:0] b_wa, b_ra;
   logic [SLOT_W:0]   b_wd, b_rd;

   logic              b_busy;
   logic [SLOT_W-1:0] b_pos;
   logic [SLOT_W-1:0] last_pos;
   logic [SLOT_W-1:0] hole_sel;
   logic              pool_full, pool_empty, idx_beyond_pool, idx_ge_count;
   logic              alloc_ok;
   status_type        err_code;
   logic [SLOT_W-1:0]  res_slot, res_pos;
   logic [COUNT_W-1:0] res_used;

   // Slot at each dense position
   dsia_ram #(
      .WIDTH (SLOT_W),
      .DEPTH (POOL_SLOTS)
   ) u_slot_tbl (
      .clock   (clock),
      .wr_en   (a_we),
      .wr_addr (a_wa),
      .wr_data (a_wd),
      .rd_en   (a_re),
      .rd_addr (a_ra),
      .rd_data (a_rd)
   );

   // Busy flag and dense position of each slot
   dsia_ram #(
      .WIDTH (SLOT_W + 1),
      .DEPTH (POOL_SLOTS)
   ) u_pos_tbl (
      .clock   (clock),
      .wr_en   (b_we),
      .wr_addr (b_wa),
      .wr_data (b_wd),
      .rd_en   (b_re),
      .rd_addr (b_ra),
      .rd_data (b_rd)
   );

   assign b_busy   = b_rd[SLOT_W];
   assign b_pos    = b_rd[SLOT_W-1:0];
   assign last_pos = SLOT_W'(count_ff - COUNT_W'(1));
   assign hole_sel = (mode_ff == OP_FREE_SLOT) ? b_pos : hole_ff;

   // Range and occupancy checks
   assign pool_full = (CMP_W'(count_ff) >= CMP_W'(active_slots)) ||
                      (CMP_W'(count_ff) >= CMP_W'(POOL_SLOTS));
   assign pool_empty      = (count_ff == '0);
   assign idx_beyond_pool = (CMP_W'(idx_ff) >= CMP_W'(POOL_SLOTS));
   assign idx_ge_count    = (CMP_W'(idx_ff) >= CMP_W'(count_ff));

   // Classify the captured request
   always_comb begin
      err_code = ST_OK;
      case (mode_ff) inside
         OP_ALLOC, OP_PEEK: begin
            if (pool_full) begin
               err_code = ST_FULL;
            end
         end
         OP_FREE_SLOT, OP_POS_OF: begin
            if (pool_empty) begin
               err_code = ST_EMPTY;
            end else if (idx_beyond_pool || !b_busy) begin
               err_code = ST_NOT_ALLOC;
            end
         end
         OP_FREE_POS: begin
            if (pool_empty) begin
               err_code = ST_EMPTY;
            end else if (idx_ge_count) begin
               err_code = ST_RANGE;
            end
         end
         OP_SLOT_OF: begin
            if (idx_ge_count) begin
               err_code = ST_RANGE;
            end
         end
         default: begin
            err_code = ST_OK;
         end
      endcase
   end

   assign alloc_ok = cmd.finish && (mode_ff == OP_ALLOC) && (err_code == ST_OK);

   // Read addresses: launched from the request itself, or the last used entry
   always_comb begin
      a_re = cmd.accept || cmd.fetch_last;
      b_re = cmd.accept;
      b_ra = SLOT_W'(req_index);
      a_ra = SLOT_W'(req_index);
      if (cmd.fetch_last) begin
         a_ra = last_pos;
      end else begin
         case (req_mode) inside
            OP_ALLOC, OP_PEEK: a_ra = SLOT_W'(count_ff);
            OP_FREE_SLOT:      a_ra = last_pos;
            default:           a_ra = SLOT_W'(req_index);
         endcase
      end
   end

   // Write ports: clearing pass, allocation, and the two steps of a free
   always_comb begin
      a_we = 1'b0;
      a_wa = clr_ff;
      a_wd = clr_ff;
      b_we = 1'b0;
      b_wa = clr_ff;
      b_wd = '0;
      if (cmd.clear) begin
         a_we = 1'b1;
         b_we = 1'b1;
      end
      if (cmd.free_move) begin
         a_we = 1'b1;
         a_wa = hole_sel;
         a_wd = a_rd;
         b_we = 1'b1;
         b_wa = a_rd;
         b_wd = {1'b1, hole_sel};
      end
      if (cmd.retire) begin
         a_we = 1'b1;
         a_wa = last_pos;
         a_wd = s_ff;
         b_we = 1'b1;
         b_wa = s_ff;
         b_wd = {1'b0, hole_ff};
      end
      if (alloc_ok) begin
         b_we = 1'b1;
         b_wa = a_rd;
         b_wd = {1'b1, SLOT_W'(count_ff)};
      end
   end

   // Result of a single-read operation
   always_comb begin
      res_slot = '0;
      res_pos  = '0;
      res_used = count_ff;
      if (err_code == ST_OK) begin
         case (mode_ff) inside
            OP_ALLOC: begin
               res_slot = a_rd;
               res_pos  = SLOT_W'(count_ff);
               res_used = count_ff + COUNT_W'(1);
            end
            OP_PEEK: begin
               res_slot = a_rd;
               res_pos  = SLOT_W'(count_ff);
            end
            OP_SLOT_OF: begin
               res_slot = a_rd;
               res_pos  = SLOT_W'(idx_ff);
            end
            OP_POS_OF: begin
               res_slot = SLOT_W'(idx_ff);
               res_pos  = b_pos;
            end
            default: begin
               res_slot = '0;
            end
         endcase
      end
   end

   // Next values of all registers
   always_comb begin
      mode_in       = mode_ff;
      idx_in        = idx_ff;
      s_in          = s_ff;
      hole_in       = hole_ff;
      count_in      = count_ff;
      clr_in        = clr_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_used_in   = rsp_used_ff;

      if (cmd.clear) begin
         clr_in = clr_ff + SLOT_W'(1);
      end
      if (cmd.accept) begin
         mode_in = req_mode;
         idx_in  = req_index;
      end
      if (cmd.fetch_last) begin
         s_in    = a_rd;
         hole_in = SLOT_W'(idx_ff);
      end
      if (cmd.free_move) begin
         hole_in = hole_sel;
         if (mode_ff == OP_FREE_SLOT) begin
            s_in = SLOT_W'(idx_ff);
         end
      end

      // Drop the response once taken
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.finish) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = err_code;
         rsp_slot_in   = SLOT_OUT_W'(res_slot);
         rsp_pos_in    = POS_OUT_W'(res_pos);
         rsp_used_in   = USED_W'(res_used);
         count_in      = res_used;
      end
      if (cmd.retire) begin
         count_in      = count_ff - COUNT_W'(1);
         rsp_valid_in  = 1'b1;
         rsp_status_in = ST_OK;
         rsp_slot_in   = SLOT_OUT_W'(s_ff);
         rsp_pos_in    = POS_OUT_W'(hole_ff);
         rsp_used_in   = USED_W'(count_ff - COUNT_W'(1));
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      idx_ff        <= idx_in;
      s_ff          <= s_in;
      hole_ff       <= hole_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_used_ff   <= rsp_used_in;
   end

   assign stat.mode       = mode_ff;
   assign stat.err        = (err_code != ST_OK);
   assign stat.clear_last = (clr_ff == SLOT_W'(POOL_SLOTS - 1));
   assign stat.out_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_slot       = rsp_slot_ff;
   assign rsp_position   = rsp_pos_ff;
   assign rsp_used_count = rsp_used_ff;

`ifndef SYNTH
   // A response is loaded only into a free output register
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.finish || cmd.retire) |-> stat.out_free)
      else $error("response loaded over a pending transfer");

   // A free never starts on an empty pool
   a_move_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.free_move |-> (count_ff != '0))
      else $error("free move with empty pool");

   // Retiring a free lowers the use count by one
   a_retire_dec: assert property (@(posedge clock) disable iff (reset)
      cmd.retire |=> (count_ff == COUNT_W'($past(count_ff) - COUNT_W'(1))))
      else $error("use count not decremented on free");

   // A successful allocate raises the use count by one
   a_alloc_inc: assert property (@(posedge clock) disable iff (reset)
      alloc_ok |=> (count_ff == COUNT_W'($past(count_ff) + COUNT_W'(1))))
      else $error("use count not incremented on allocate");
`endif

endmodule

FILE: design/dense_slot_index_allocator.sv
// Top level: stream request and response channels, register port, controller and datapath.
`timescale 1ns / 1ps

// Dense slot allocator over POOL_SLOTS slots. After reset the block runs a
// clearing pass that loads the identity permutation into
// the slot table; req_tready stays low during it, register writes are taken.
// Requests are handled one at a time. Allocate, peek, both lookups and every
// request that ends in an error are accepted, then finish on the registered
// table read. Free by slot runs EXEC then RETIRE after accept, free by position
// EXEC, FETCH, RETIRE: the slot table has one write port and one read port,
// and a free writes it twice, so the hole fill and the parking of the freed
// slot go in separate cycles, and free by position reads it twice. Responses
// land in an output register, so a request is accepted while one is pending.

module dense_slot_index_allocator
   import dsia_pkg::*;
#(
   parameter int POOL_SLOTS = 256
) (
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // mode[2:0], index[10:3]

   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // status[2:0], slot[10:3],
                                              // position[18:11], used_count[27:19]

   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic [ACTIVE_W-1:0] active_ff, active_in;
   logic                csr_hit;

   dp_cmd_type    cmd;
   dp_status_type stat;

   logic [STATUS_W-1:0]   rsp_status;
   logic [SLOT_OUT_W-1:0] rsp_slot;
   logic [POS_OUT_W-1:0]  rsp_position;
   logic [USED_W-1:0]     rsp_used_count;

   // Register port: one register, word index from paddr[2]
   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[2] == CSR_IDX_ACTIVE);

   always_comb begin
      active_in = active_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_hit) begin
         active_in = csr_pwdata[ACTIVE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= ACTIVE_RESET;
      end else begin
         active_ff <= active_in;
      end
   end

   assign csr_prdata = csr_hit ? CSR_DATA_W'(active_ff) : '0;

   dsia_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .stat      (stat),
      .cmd       (cmd)
   );

   dsia_datapath #(
      .POOL_SLOTS (POOL_SLOTS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_mode       (req_tdata[MODE_W-1:0]),
      .req_index      (req_tdata[MODE_W +: INDEX_W]),
      .active_slots   (active_ff),
      .rsp_ready      (rsp_tready),
      .rsp_valid      (rsp_tvalid),
      .rsp_status     (rsp_status),
      .rsp_slot       (rsp_slot),
      .rsp_position   (rsp_position),
      .rsp_used_count (rsp_used_count)
   );

   // Pack the response transfer
   assign rsp_tdata = {
      (RSP_DATA_W - STATUS_W - SLOT_OUT_W - POS_OUT_W - USED_W)'(0),
      rsp_used_count, rsp_position, rsp_slot, rsp_status
   };

endmodule
